// ===== rtl/core/rsrg_pkg.sv =====
// Shared types, constants and the key compare for the replacement-selection run generator.
`default_nettype none

package rsrg_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VAL_W        = 32;
	localparam int RUN_W        = 16;

	// Commands that every cell of the sorted chain carries out together.
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_REP  = 2'd2;
	localparam logic [1:0] CELL_DRN  = 2'd3;

	// Sort key: entries waiting for the next run order after the current run.
	typedef struct packed {
		logic                    nxt;
		logic signed [VAL_W-1:0] val;
	} key_t;

	// Command broadcast from the controller to the cell chain.
	typedef struct packed {
		logic [1:0] op;
		logic       clear;
		key_t       key;
	} cell_cmd_t;

	// True when key a sorts at or before key b.
	function automatic logic key_le(input key_t a, input key_t b);
		logic res;
		if (a.nxt != b.nxt) begin
			res = b.nxt;
		end else begin
			res = (a.val <= b.val);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rsrg_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none

module rsrg_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rsrg_pkg::cell_cmd_t cmd,
	input  wire logic               head,
	input  wire rsrg_pkg::key_t     left_key,
	input  wire logic               left_valid,
	input  wire logic               left_le,
	input  wire rsrg_pkg::key_t     right_key,
	input  wire logic               right_valid,
	input  wire logic               right_le,
	output rsrg_pkg::key_t          key_q,
	output logic                    valid_q,
	output logic                    le
);

	rsrg_pkg::key_t key_d;
	logic           valid_d;

	// The held entry sorts at or before the key being inserted.
	assign le = valid_q && rsrg_pkg::key_le(key_q, cmd.key);

	// Next content of the cell for each chain command.
	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		if (cmd.clear) begin
			key_d.nxt = 1'b0;
		end
		case (cmd.op)
			rsrg_pkg::CELL_INS: begin
				if (le) begin
					key_d = key_q;
				end else if (head || left_le) begin
					key_d   = cmd.key;
					valid_d = 1'b1;
				end else begin
					// Shift right: the cell takes over its left neighbor's entry.
					key_d   = left_key;
					valid_d = left_valid;
				end
			end
			rsrg_pkg::CELL_REP: begin
				if (right_le) begin
					key_d = right_key;
				end else if (head || le) begin
					key_d = cmd.key;
				end else begin
					key_d = key_q;
				end
				valid_d = 1'b1;
			end
			rsrg_pkg::CELL_DRN: begin
				key_d   = right_key;
				valid_d = right_valid;
			end
			default: begin
				key_d   = key_d;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/replacement_selection_run_generator_core.sv =====
// Top level of the replacement-selection run generator: controller and sorted cell chain.
//
// Run generation by replacement selection for an external sort. Entries are kept in a
// chain of CAPACITY cells, sorted by (waits-for-next-run, value), so the smallest entry
// of the current run always sits in the first cell. Inserts fill the store without a
// result; once it is full each insert emits that entry and the new value takes its place
// in the chain; drains emit the rest in run order, and a drain on an empty store returns
// a result with empty_res set. Each item is first accepted, with the run bookkeeping worked
// out, and is then applied to the chain, where every cell moves in step with its neighbors.
// The chain update waits while the previous result has not been taken, so the next item
// can be accepted while a result is still pending.
`default_nettype none

module replacement_selection_run_generator_core #(
	parameter int CAPACITY = rsrg_pkg::CAPACITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             op,
	input  wire logic signed [rsrg_pkg::VAL_W-1:0] value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [rsrg_pkg::VAL_W-1:0]     out_value,
	output logic [rsrg_pkg::RUN_W-1:0]            run_number,
	output logic                                  first_of_run,
	output logic                                  empty_res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                          st_q;
	logic [CNT_W-1:0]              held_q;
	logic [CNT_W-1:0]              cur_q;
	logic [rsrg_pkg::RUN_W-1:0]    run_q;
	logic                          started_q;

	logic [1:0]                    op_s1;
	rsrg_pkg::key_t                key_s1;
	logic                          has_res_s1;
	logic signed [rsrg_pkg::VAL_W-1:0] res_value_s1;
	logic [rsrg_pkg::RUN_W-1:0]    res_run_s1;
	logic                          res_first_s1;
	logic                          res_empty_s1;

	logic                          out_valid_q;
	logic signed [rsrg_pkg::VAL_W-1:0] out_value_q;
	logic [rsrg_pkg::RUN_W-1:0]    run_number_q;
	logic                          first_q;
	logic                          empty_q;

	logic                          accept;
	logic                          exec;
	logic                          full;
	logic                          emit;
	logic                          fill;
	logic                          drain_empty;
	logic                          do_begin;
	logic                          started_eff;
	logic [rsrg_pkg::RUN_W-1:0]    run_eff;
	logic [CNT_W-1:0]              cur_eff;
	logic signed [rsrg_pkg::VAL_W-1:0] head_val;
	logic                          new_nxt;

	rsrg_pkg::cell_cmd_t           cmd;
	rsrg_pkg::key_t                cell_key   [CAPACITY];
	logic                          cell_valid [CAPACITY];
	logic                          cell_le    [CAPACITY];

	assign in_ready = (st_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign exec     = (st_q == ST_EXEC) && (!out_valid_q || out_ready);

	// Classify the incoming item and work out the run bookkeeping.
	assign head_val    = cell_key[0].val;
	assign full        = (held_q == CNT_W'(CAPACITY));
	assign fill        = !op && !full;
	assign emit        = (!op && full) || (op && (held_q != '0));
	assign drain_empty = op && (held_q == '0);
	assign do_begin    = emit && (cur_q == '0);
	assign started_eff = do_begin ? 1'b0 : started_q;
	assign run_eff     = do_begin ? run_q + rsrg_pkg::RUN_W'(1) : run_q;
	assign cur_eff     = do_begin ? held_q : cur_q;
	assign new_nxt     = (value < head_val);

	// Controller state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			held_q    <= '0;
			cur_q     <= '0;
			run_q     <= '0;
			started_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q <= ST_EXEC;
				if (fill) begin
					held_q <= held_q + CNT_W'(1);
					if (!started_q) begin
						cur_q <= cur_q + CNT_W'(1);
					end
				end else if (emit) begin
					run_q     <= run_eff;
					started_q <= 1'b1;
					if (op) begin
						held_q <= held_q - CNT_W'(1);
						cur_q  <= cur_eff - CNT_W'(1);
					end else begin
						cur_q <= cur_eff - CNT_W'(new_nxt);
					end
				end
			end else if (exec) begin
				st_q <= ST_IDLE;
			end
		end
	end

	// Item register between the bookkeeping cycle and the chain update.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (fill) begin
				op_s1 <= rsrg_pkg::CELL_INS;
			end else if (emit && !op) begin
				op_s1 <= rsrg_pkg::CELL_REP;
			end else if (emit) begin
				op_s1 <= rsrg_pkg::CELL_DRN;
			end else begin
				op_s1 <= rsrg_pkg::CELL_HOLD;
			end
			key_s1.nxt   <= fill ? started_q : new_nxt;
			key_s1.val   <= value;
			has_res_s1   <= emit || drain_empty;
			res_value_s1 <= emit ? head_val : '0;
			res_run_s1   <= run_eff;
			res_first_s1 <= emit && !started_eff;
			res_empty_s1 <= drain_empty;
		end
	end

	// Command broadcast to all cells; a run start clears the next-run marks at once.
	always_comb begin
		cmd.op    = exec ? op_s1 : rsrg_pkg::CELL_HOLD;
		cmd.clear = accept && do_begin;
		cmd.key   = key_s1;
	end

	// Sorted chain of cells, each trading entries with its neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rsrg_pkg::key_t left_key;
		logic           left_valid;
		logic           left_le;
		rsrg_pkg::key_t right_key;
		logic           right_valid;
		logic           right_le;

		if (i == 0) begin : g_left_edge
			assign left_key   = '0;
			assign left_valid = 1'b0;
			assign left_le    = 1'b0;
		end else begin : g_left
			assign left_key   = cell_key[i-1];
			assign left_valid = cell_valid[i-1];
			assign left_le    = cell_le[i-1];
		end

		if (i == CAPACITY - 1) begin : g_right_edge
			assign right_key   = '0;
			assign right_valid = 1'b0;
			assign right_le    = 1'b0;
		end else begin : g_right
			assign right_key   = cell_key[i+1];
			assign right_valid = cell_valid[i+1];
			assign right_le    = cell_le[i+1];
		end

		rsrg_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.head        ((i == 0) ? 1'b1 : 1'b0),
			.left_key    (left_key),
			.left_valid  (left_valid),
			.left_le     (left_le),
			.right_key   (right_key),
			.right_valid (right_valid),
			.right_le    (right_le),
			.key_q       (cell_key[i]),
			.valid_q     (cell_valid[i]),
			.le          (cell_le[i])
		);
	end

	// Output register; a result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && has_res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && has_res_s1) begin
			out_value_q  <= res_value_s1;
			run_number_q <= res_run_s1;
			first_q      <= res_first_s1;
			empty_q      <= res_empty_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign run_number   = run_number_q;
	assign first_of_run = first_q;
	assign empty_res    = empty_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the replacement-selection run generator core.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = rsrg_pkg::CAPACITY_DEF;
	localparam int VW  = rsrg_pkg::VAL_W;
	localparam int RW  = rsrg_pkg::RUN_W;

	localparam bit OP_INSERT = 1'b0;
	localparam bit OP_DRAIN  = 1'b1;

	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DIR_N        = 21;

	localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

	// One emitted value, or an empty report.
	typedef struct packed {
		logic signed [VW-1:0] val;
		logic [RW-1:0]        run;
		logic                 first;
		logic                 empty;
	} sort_out_t;

	localparam sort_out_t NO_RES = '0;

	// One row of the directed stimulus; typed rows carry their result.
	typedef struct {
		bit                   cmd;
		logic signed [VW-1:0] v;
		bit                   typed;
		sort_out_t            want;
	} stim_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 op           = 1'b0;
	logic signed [VW-1:0] value        = '0;
	logic                 out_ready    = 1'b0;
	wire logic            in_ready;
	wire logic            out_valid;
	wire logic signed [VW-1:0] out_value;
	wire logic [RW-1:0]   run_number;
	wire logic            first_of_run;
	wire logic            empty_res;

	// Predictor state: the store, its run marks and the run bookkeeping.
	logic signed [VW-1:0] store_val [CAP];
	bit                   store_later [CAP];
	int                   held_n      = 0;
	int                   run_left    = 0;
	logic [RW-1:0]        run_id      = '0;
	bit                   run_emitted = 1'b0;

	sort_out_t            sorted_q [$];
	int                   errors      = 0;
	int                   items_sent  = 0;
	int                   burst_left  = 1;
	int                   cycle_count = 0;
	int                   rx_cycle    = 0;
	logic signed [VW-1:0] trend_base  = '0;

	// Directed rows: empty drain, extremes, ties, refill after drains, run change.
	stim_row_t dir_tab [DIR_N] = '{
		'{OP_DRAIN,  32'sd0,           1'b1, '{32'sd0, 16'd0, 1'b0, 1'b1}},
		'{OP_INSERT, VAL_MAX,          1'b0, NO_RES},
		'{OP_INSERT, VAL_MIN,          1'b0, NO_RES},
		'{OP_INSERT, 32'sd5,           1'b0, NO_RES},
		'{OP_INSERT, 32'sd5,           1'b0, NO_RES},
		'{OP_INSERT, 32'sd0,           1'b0, NO_RES},
		'{OP_INSERT, -32'sd1,          1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b1, '{VAL_MIN, 16'd0, 1'b1, 1'b0}},
		'{OP_INSERT, 32'sd3,           1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b1, '{VAL_MAX, 16'd0, 1'b0, 1'b0}},
		'{OP_DRAIN,  32'sd0,           1'b1, '{32'sd3, 16'd1, 1'b1, 1'b0}},
		'{OP_DRAIN,  -32'sd1,          1'b1, '{32'sd0, 16'd1, 1'b0, 1'b1}},
		'{OP_INSERT, 32'sh5555_5555,   1'b0, NO_RES},
		'{OP_INSERT, 32'shAAAA_AAAA,   1'b0, NO_RES},
		'{OP_DRAIN,  32'sd0,           1'b1, '{32'shAAAA_AAAA, 16'd2, 1'b1, 1'b0}},
		'{OP_DRAIN,  32'sd0,           1'b1, '{32'sh5555_5555, 16'd2, 1'b0, 1'b0}},
		'{OP_DRAIN,  32'sd0,           1'b1, '{32'sd0, 16'd2, 1'b0, 1'b1}}
	};

	replacement_selection_run_generator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.run_number   (run_number),
		.first_of_run (first_of_run),
		.empty_res    (empty_res)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every held entry joins a fresh run.
	function automatic void start_run();
		for (int i = 0; i < held_n; i++) begin
			store_later[i] = 1'b0;
		end
		run_left    = held_n;
		run_id      = run_id + 1'b1;
		run_emitted = 1'b0;
	endfunction

	// Slot of the smallest current-run entry; ties go to the lowest slot.
	function automatic int min_slot();
		int best;
		bit found;
		best  = 0;
		found = 1'b0;
		for (int i = 0; i < held_n; i++) begin
			if (!store_later[i] && (!found || store_val[i] < store_val[best])) begin
				best  = i;
				found = 1'b1;
			end
		end
		return best;
	endfunction

	// Result for an emitted value; marks the run as started.
	function automatic sort_out_t emit_value(input logic signed [VW-1:0] m);
		sort_out_t r;
		r.val       = m;
		r.run       = run_id;
		r.first     = !run_emitted;
		r.empty     = 1'b0;
		run_emitted = 1'b1;
		return r;
	endfunction

	// Applies one accepted item to the predicted store and returns its result.
	task automatic predict_sort(input bit cmd, input logic signed [VW-1:0] v,
			output bit got, output sort_out_t res);
		int slot;
		logic signed [VW-1:0] m;
		got = 1'b0;
		res = NO_RES;
		if (cmd == OP_INSERT) begin
			if (held_n < CAP) begin
				store_val[held_n]   = v;
				store_later[held_n] = run_emitted;
				if (!run_emitted) begin
					run_left++;
				end
				held_n++;
			end else begin
				if (run_left == 0) begin
					start_run();
				end
				slot = min_slot();
				m    = store_val[slot];
				res  = emit_value(m);
				got  = 1'b1;
				store_val[slot] = v;
				if (v >= m) begin
					store_later[slot] = 1'b0;
				end else begin
					store_later[slot] = 1'b1;
					run_left--;
				end
			end
		end else if (held_n == 0) begin
			res.val   = '0;
			res.run   = run_id;
			res.first = 1'b0;
			res.empty = 1'b1;
			got       = 1'b1;
		end else begin
			if (run_left == 0) begin
				start_run();
			end
			slot = min_slot();
			m    = store_val[slot];
			res  = emit_value(m);
			got  = 1'b1;
			held_n--;
			store_val[slot]   = store_val[held_n];
			store_later[slot] = store_later[held_n];
			run_left--;
		end
	endtask

	// Drives one item, waits for its transfer, records the expectation, then idles in bursts.
	task automatic send_item(input bit cmd, input logic signed [VW-1:0] v,
			input bit typed, input sort_out_t want);
		bit got;
		sort_out_t pred;
		in_valid <= 1'b1;
		op       <= cmd;
		value    <= v;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_sort(cmd, v, got, pred);
		if (typed) begin
			sorted_q.push_back(want);
		end else if (got) begin
			sorted_q.push_back(pred);
		end
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			op       <= 1'($urandom_range(0, 1));
			value    <= $urandom;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 120);
			end else begin
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// Holds the sender off until every expected result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_q.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Random values: full range, a narrow band for ties, extremes, and rising trends.
	function automatic logic signed [VW-1:0] pick_value();
		int sel;
		logic signed [VW-1:0] r;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			r = $urandom;
		end else if (sel < 60) begin
			r = $urandom_range(0, 16);
			r = r - 8;
		end else if (sel < 75) begin
			case ($urandom_range(0, 4))
				0: r = VAL_MAX;
				1: r = VAL_MIN;
				2: r = 32'sd0;
				3: r = -32'sd1;
				default: r = 32'sd1;
			endcase
		end else begin
			if ($urandom_range(0, 19) == 0) begin
				trend_base = $urandom;
			end
			r          = $urandom_range(0, 200);
			trend_base = trend_base + r - 60;
			r          = trend_base;
		end
		return r;
	endfunction

	// Result check: each transfer on the output is matched to the oldest expectation.
	always @(posedge clk) begin
		sort_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected result out_value=%0d run_number=%0d first=%0b empty=%0b",
					$time, out_value, run_number, first_of_run, empty_res);
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (out_value !== want.val) begin
					$display("%0t: out_value expected %0d actual %0d", $time, want.val, out_value);
					errors++;
				end
				if (run_number !== want.run) begin
					$display("%0t: run_number expected %0d actual %0d", $time, want.run,
						run_number);
					errors++;
				end
				if (first_of_run !== want.first) begin
					$display("%0t: first_of_run expected %0b actual %0b", $time, want.first,
						first_of_run);
					errors++;
				end
				if (empty_res !== want.empty) begin
					$display("%0t: empty_res expected %0b actual %0b", $time, want.empty,
						empty_res);
					errors++;
				end
			end
		end
	end

	// Receiver stalls follow a pattern that steps through four modes in turn.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 300) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ((rx_cycle % 5) == 0);
			default: out_ready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Main sequence: reset, directed rows, random fill and drain sequences, then wind-down.
	initial begin
		int n;
		int sel;
		int random_start;
		for (int i = 0; i < CAP; i++) begin
			store_val[i]   = '0;
			store_later[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_item(dir_tab[i].cmd, dir_tab[i].v, dir_tab[i].typed, dir_tab[i].want);
		end
		wait_drained();

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			// Fill phase, mostly past the full mark so inserts emit, with a few stray drains.
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				n = CAP - held_n + $urandom_range(0, 100);
			end else if (sel < 90) begin
				n = $urandom_range(1, 20);
			end else begin
				n = 0;
			end
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 8) begin
					send_item(OP_DRAIN, $urandom, 1'b0, NO_RES);
				end else begin
					send_item(OP_INSERT, pick_value(), 1'b0, NO_RES);
				end
			end

			// Drain phase: usually to empty and past it, sometimes partway.
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				n = held_n + $urandom_range(0, 2);
			end else if (sel < 90) begin
				n = $urandom_range(0, held_n);
			end else begin
				n = 0;
			end
			for (int k = 0; k < n; k++) begin
				send_item(OP_DRAIN, $urandom, 1'b0, NO_RES);
			end

			if ($urandom_range(0, 5) == 0) begin
				wait_drained();
			end
		end

		in_valid <= 1'b0;
		while (sorted_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
